/* rtl/core/baro_pkg.sv */
`timescale 1ns / 1ps

package baro_pkg;

   // calibration word register indexes
   typedef enum logic [2:0] {
      CSR_PRESSURE_SENSITIVITY   = 3'd0,
      CSR_PRESSURE_OFFSET        = 3'd1,
      CSR_SENSITIVITY_TEMP_COEFF = 3'd2,
      CSR_OFFSET_TEMP_COEFF      = 3'd3,
      CSR_REFERENCE_TEMPERATURE  = 3'd4,
      CSR_TEMPERATURE_COEFF      = 3'd5
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CAL_W       = 16;
   localparam int RAW_W       = 24;
   localparam int RESULT_W    = 32;

   // calibration reset values
   localparam logic [CAL_W-1:0] C1_RESET = 16'd46372;
   localparam logic [CAL_W-1:0] C2_RESET = 16'd43981;
   localparam logic [CAL_W-1:0] C3_RESET = 16'd29059;
   localparam logic [CAL_W-1:0] C4_RESET = 16'd27842;
   localparam logic [CAL_W-1:0] C5_RESET = 16'd31553;
   localparam logic [CAL_W-1:0] C6_RESET = 16'd28165;

   // internal widths, sized to the value ranges
   localparam int DT_W    = RAW_W + 1;          // dT, signed
   localparam int COEF_W  = CAL_W + 1;          // calibration word as signed
   localparam int PROD_W  = DT_W + COEF_W - 1;  // dT * Cx
   localparam int DTSQ_W  = 2 * DT_W;           // dT * dT
   localparam int TEMP_W  = 20;                 // temperatures and deltas
   localparam int SQ_W    = 37;                 // squared temperature deltas
   localparam int OFF_W   = 42;                 // OFF, SENS and corrections
   localparam int SENS_LO_W = 21;               // low split of SENS
   localparam int SENS_HI_W = OFF_W - SENS_LO_W;
   localparam int PHI_W   = DT_W + SENS_HI_W;   // D1 * SENS high part
   localparam int PLO_W   = RAW_W + SENS_LO_W;  // D1 * SENS low part
   localparam int P1_W    = 47;                 // pressure before final shift

   // shift amounts
   localparam int C5_SHIFT   = 8;
   localparam int TEMP_SHIFT = 23;
   localparam int OFF_SHIFT  = 6;
   localparam int SENS_SHIFT = 7;
   localparam int C2_SHIFT   = 17;
   localparam int C1_SHIFT   = 16;
   localparam int T2_SHIFT   = 31;
   localparam int OFF2_SHIFT = 4;
   localparam int P_SHIFT    = 15;

   // temperature thresholds in 0.01 degC
   localparam int TEMP_REF        = 2000;
   localparam int VERY_COLD_LIMIT = -1500;

   localparam int PIPE_DEPTH = 7;

endpackage

/* rtl/core/baro_sensor_compensation.sv */
`timescale 1ns / 1ps

// Barometric sensor compensation pipeline.
// Request channel: a transaction is taken at a rising edge with start high and
// busy low. busy is held low: the pipeline takes one raw pressure/temperature
// pair every cycle, so throughput is one transaction per clock.
// Response channel: rsp_valid strobes for exactly one cycle with rsp_pressure
// (0.01 mbar) and rsp_temperature (0.01 degC). Each request passes through
// seven register stages (dT, products, first order terms, squares, second
// order correction, D1*SENS partial products, output).
// Results leave in request order, one per request.
// The receiver cannot stall; the pipeline never holds and never drops data.
// CSR port: csr_we with csr_index selects one of six 16-bit calibration words
// C1..C6; unknown indexes are ignored. Write only while no transaction is in
// flight, since the stages read the words directly.
// Reset (synchronous, active high) empties the pipeline and loads the factory
// default calibration words.
module baro_sensor_compensation (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [baro_pkg::RAW_W-1:0]            req_raw_pressure,
   input  logic [baro_pkg::RAW_W-1:0]            req_raw_temperature,
   output logic                                  rsp_valid,
   output logic signed [baro_pkg::RESULT_W-1:0]  rsp_pressure,
   output logic signed [baro_pkg::RESULT_W-1:0]  rsp_temperature,
   input  logic                                  csr_we,
   input  logic [baro_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [baro_pkg::CAL_W-1:0]            csr_wdata
);

   localparam int RAW_W  = baro_pkg::RAW_W;
   localparam int CAL_W  = baro_pkg::CAL_W;
   localparam int DT_W   = baro_pkg::DT_W;
   localparam int COEF_W = baro_pkg::COEF_W;
   localparam int PROD_W = baro_pkg::PROD_W;
   localparam int DTSQ_W = baro_pkg::DTSQ_W;
   localparam int TEMP_W = baro_pkg::TEMP_W;
   localparam int SQ_W   = baro_pkg::SQ_W;
   localparam int OFF_W  = baro_pkg::OFF_W;
   localparam int LO_W   = baro_pkg::SENS_LO_W;
   localparam int HI_W   = baro_pkg::SENS_HI_W;
   localparam int PHI_W  = baro_pkg::PHI_W;
   localparam int PLO_W  = baro_pkg::PLO_W;
   localparam int P1_W   = baro_pkg::P1_W;
   localparam int DEPTH  = baro_pkg::PIPE_DEPTH;
   localparam int RES_W  = baro_pkg::RESULT_W;

   // ---------------------------------------------------------------------
   // Calibration words
   // ---------------------------------------------------------------------
   logic [CAL_W-1:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= baro_pkg::C1_RESET;
         c2_ff <= baro_pkg::C2_RESET;
         c3_ff <= baro_pkg::C3_RESET;
         c4_ff <= baro_pkg::C4_RESET;
         c5_ff <= baro_pkg::C5_RESET;
         c6_ff <= baro_pkg::C6_RESET;
      end else if (csr_we) begin
         case (baro_pkg::csr_index_type'(csr_index))
            baro_pkg::CSR_PRESSURE_SENSITIVITY:   c1_ff <= csr_wdata;
            baro_pkg::CSR_PRESSURE_OFFSET:        c2_ff <= csr_wdata;
            baro_pkg::CSR_SENSITIVITY_TEMP_COEFF: c3_ff <= csr_wdata;
            baro_pkg::CSR_OFFSET_TEMP_COEFF:      c4_ff <= csr_wdata;
            baro_pkg::CSR_REFERENCE_TEMPERATURE:  c5_ff <= csr_wdata;
            baro_pkg::CSR_TEMPERATURE_COEFF:      c6_ff <= csr_wdata;
            default: ;  // unknown index: ignored
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake and valid pipe
   // ---------------------------------------------------------------------
   logic             accept;
   logic [DEPTH-1:0] valid_ff, valid_in;

   assign busy     = 1'b0;
   assign accept   = start & ~busy;
   assign valid_in = {valid_ff[DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[DEPTH-1];

   // ---------------------------------------------------------------------
   // Stage 1: dT = D2 - C5*256
   // ---------------------------------------------------------------------
   logic signed [DT_W-1:0] dt_s1_ff, dt_s1_in;
   logic [RAW_W-1:0]       d1_s1_ff;

   assign dt_s1_in = $signed({1'b0, req_raw_temperature})
                   - $signed({1'b0, c5_ff, {baro_pkg::C5_SHIFT{1'b0}}});

   // ---------------------------------------------------------------------
   // Stage 2: dT products
   // ---------------------------------------------------------------------
   logic signed [COEF_W-1:0] c3_s, c4_s, c6_s;
   logic signed [PROD_W-1:0] pt_s2_ff, pt_s2_in;   // dT*C6
   logic signed [PROD_W-1:0] po_s2_ff, po_s2_in;   // C4*dT
   logic signed [PROD_W-1:0] ps_s2_ff, ps_s2_in;   // C3*dT
   logic signed [DTSQ_W-1:0] dq_s2_ff, dq_s2_in;   // dT*dT
   logic [RAW_W-1:0]         d1_s2_ff;

   assign c3_s     = $signed({1'b0, c3_ff});
   assign c4_s     = $signed({1'b0, c4_ff});
   assign c6_s     = $signed({1'b0, c6_ff});
   assign pt_s2_in = dt_s1_ff * c6_s;
   assign po_s2_in = c4_s * dt_s1_ff;
   assign ps_s2_in = c3_s * dt_s1_ff;
   assign dq_s2_in = dt_s1_ff * dt_s1_ff;

   // ---------------------------------------------------------------------
   // Stage 3: first order TEMP, OFF, SENS; deltas for the cold correction
   // ---------------------------------------------------------------------
   logic signed [PROD_W-1:0] pt_shift;
   logic signed [OFF_W-1:0]  off_adj, sens_adj;
   logic signed [TEMP_W-1:0] tm_s3_ff, tm_s3_in;     // TEMP - 2000
   logic signed [TEMP_W-1:0] tp_s3_ff, tp_s3_in;     // TEMP + 1500
   logic signed [TEMP_W-1:0] temp_s3_ff, temp_s3_in;
   logic signed [TEMP_W-1:0] t2_s3_ff, t2_s3_in;
   logic signed [OFF_W-1:0]  off_s3_ff, off_s3_in;
   logic signed [OFF_W-1:0]  sens_s3_ff, sens_s3_in;
   logic [RAW_W-1:0]         d1_s3_ff;

   // TEMP - 2000 is the shifted product itself, so the cold tests
   // are sign checks and run beside the TEMP add
   assign pt_shift   = pt_s2_ff >>> baro_pkg::TEMP_SHIFT;
   assign tm_s3_in   = TEMP_W'(pt_shift);
   assign temp_s3_in = tm_s3_in + TEMP_W'(baro_pkg::TEMP_REF);
   assign tp_s3_in   = tm_s3_in
                     + TEMP_W'(baro_pkg::TEMP_REF - baro_pkg::VERY_COLD_LIMIT);
   assign t2_s3_in   = TEMP_W'(dq_s2_ff >>> baro_pkg::T2_SHIFT);
   assign off_adj    = OFF_W'(po_s2_ff >>> baro_pkg::OFF_SHIFT);
   assign sens_adj   = OFF_W'(ps_s2_ff >>> baro_pkg::SENS_SHIFT);
   assign off_s3_in  = (OFF_W'(c2_ff) << baro_pkg::C2_SHIFT) + off_adj;
   assign sens_s3_in = (OFF_W'(c1_ff) << baro_pkg::C1_SHIFT) + sens_adj;

   // ---------------------------------------------------------------------
   // Stage 4: squares of the temperature deltas
   // ---------------------------------------------------------------------
   logic signed [2*TEMP_W-1:0] tm_sq, tp_sq;
   logic [SQ_W-1:0]            tm2_s4_ff, tm2_s4_in;
   logic [SQ_W-1:0]            tp2_s4_ff, tp2_s4_in;
   logic                       cold_s4_ff, cold_s4_in;
   logic                       vcold_s4_ff, vcold_s4_in;
   logic signed [TEMP_W-1:0]   temp_s4_ff, t2_s4_ff;
   logic signed [OFF_W-1:0]    off_s4_ff, sens_s4_ff;
   logic [RAW_W-1:0]           d1_s4_ff;

   assign tm_sq       = tm_s3_ff * tm_s3_ff;
   assign tp_sq       = tp_s3_ff * tp_s3_ff;
   assign tm2_s4_in   = SQ_W'(tm_sq);
   assign tp2_s4_in   = SQ_W'(tp_sq);
   assign cold_s4_in  = tm_s3_ff[TEMP_W-1];   // TEMP < 2000
   assign vcold_s4_in = tp_s3_ff[TEMP_W-1];   // TEMP < -1500

   // ---------------------------------------------------------------------
   // Stage 5: second order correction
   // ---------------------------------------------------------------------
   logic [OFF_W-1:0]         tm2_w, tp2_w, off2_61, off2, sens2;
   logic signed [TEMP_W-1:0] temp_s5_ff, temp_s5_in;
   logic signed [OFF_W-1:0]  off_s5_ff, off_s5_in;
   logic signed [OFF_W-1:0]  sens_s5_ff, sens_s5_in;
   logic [RAW_W-1:0]         d1_s5_ff;

   assign tm2_w   = OFF_W'(tm2_s4_ff);
   assign tp2_w   = OFF_W'(tp2_s4_ff);
   // 61*x = 64x - 2x - x; squares are non-negative so a logical shift is exact
   assign off2_61 = (tm2_w << 6) - (tm2_w << 1) - tm2_w;
   assign off2    = (off2_61 >> baro_pkg::OFF2_SHIFT)
                  + (vcold_s4_ff ? ((tp2_w << 4) - tp2_w) : '0);
   assign sens2   = (tm2_w << 1) + (vcold_s4_ff ? (tp2_w << 3) : '0);

   assign temp_s5_in = cold_s4_ff ? (temp_s4_ff - t2_s4_ff) : temp_s4_ff;
   assign off_s5_in  = cold_s4_ff ? (off_s4_ff - $signed(off2)) : off_s4_ff;
   assign sens_s5_in = cold_s4_ff ? (sens_s4_ff - $signed(sens2)) : sens_s4_ff;

   // ---------------------------------------------------------------------
   // Stage 6: D1*SENS as two partial products.
   // SENS = hi*2^21 + lo, so (D1*SENS >> 21) = D1*hi + (D1*lo >> 21).
   // ---------------------------------------------------------------------
   logic signed [HI_W-1:0]  sens_hi;
   logic [LO_W-1:0]         sens_lo;
   logic signed [PHI_W-1:0] phi_s6_ff, phi_s6_in;
   logic [PLO_W-1:0]        plo_s6_ff, plo_s6_in;
   logic signed [TEMP_W-1:0] temp_s6_ff;
   logic signed [OFF_W-1:0]  off_s6_ff;

   assign sens_hi   = sens_s5_ff[OFF_W-1:LO_W];
   assign sens_lo   = sens_s5_ff[LO_W-1:0];
   assign phi_s6_in = $signed({1'b0, d1_s5_ff}) * sens_hi;
   assign plo_s6_in = d1_s5_ff * sens_lo;

   // ---------------------------------------------------------------------
   // Stage 7: P = ((D1*SENS >> 21) - OFF) >> 15, output registers
   // ---------------------------------------------------------------------
   logic signed [P1_W-1:0]  phi_ext, off_ext, p1;
   logic [P1_W-1:0]         plo_ext;
   logic signed [RES_W-1:0] press_in, temp_out_in;

   assign phi_ext     = P1_W'(phi_s6_ff);
   assign off_ext     = P1_W'(off_s6_ff);
   assign plo_ext     = P1_W'(plo_s6_ff >> LO_W);
   assign p1          = phi_ext + $signed(plo_ext) - off_ext;
   assign press_in    = p1[baro_pkg::P_SHIFT +: RES_W];
   assign temp_out_in = RES_W'(temp_s6_ff);

   // ---------------------------------------------------------------------
   // Payload registers (no reset)
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      dt_s1_ff    <= dt_s1_in;
      d1_s1_ff    <= req_raw_pressure;

      pt_s2_ff    <= pt_s2_in;
      po_s2_ff    <= po_s2_in;
      ps_s2_ff    <= ps_s2_in;
      dq_s2_ff    <= dq_s2_in;
      d1_s2_ff    <= d1_s1_ff;

      tm_s3_ff    <= tm_s3_in;
      tp_s3_ff    <= tp_s3_in;
      temp_s3_ff  <= temp_s3_in;
      t2_s3_ff    <= t2_s3_in;
      off_s3_ff   <= off_s3_in;
      sens_s3_ff  <= sens_s3_in;
      d1_s3_ff    <= d1_s2_ff;

      tm2_s4_ff   <= tm2_s4_in;
      tp2_s4_ff   <= tp2_s4_in;
      cold_s4_ff  <= cold_s4_in;
      vcold_s4_ff <= vcold_s4_in;
      temp_s4_ff  <= temp_s3_ff;
      t2_s4_ff    <= t2_s3_ff;
      off_s4_ff   <= off_s3_ff;
      sens_s4_ff  <= sens_s3_ff;
      d1_s4_ff    <= d1_s3_ff;

      temp_s5_ff  <= temp_s5_in;
      off_s5_ff   <= off_s5_in;
      sens_s5_ff  <= sens_s5_in;
      d1_s5_ff    <= d1_s4_ff;

      phi_s6_ff   <= phi_s6_in;
      plo_s6_ff   <= plo_s6_in;
      temp_s6_ff  <= temp_s5_ff;
      off_s6_ff   <= off_s5_ff;

      rsp_pressure    <= press_in;
      rsp_temperature <= temp_out_in;
   end

endmodule

/* dv/baro_sensor_compensation_tb.sv */
`timescale 1ns / 1ps

module baro_sensor_compensation_tb;

   localparam int CSR_INDEX_W = baro_pkg::CSR_INDEX_W;
   localparam int RAW_W       = baro_pkg::RAW_W;
   localparam int CAL_W       = baro_pkg::CAL_W;
   localparam int RESULT_W    = baro_pkg::RESULT_W;
   localparam int PIPE_DEPTH  = baro_pkg::PIPE_DEPTH;
   localparam int CAL_LAST    = int'(baro_pkg::CSR_TEMPERATURE_COEFF);

   localparam int CYCLE_LIMIT   = 200_000;
   localparam int MAX_GAP       = 8;     // longest run of random idle cycles before a request
   localparam int RAND_PHASES   = 8;
   localparam int PHASE_ITEMS   = 45;
   localparam int BURST_ITEMS   = 150;

   // csr indexes that decode to nothing; writes there must not disturb C1..C6
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
   localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};

   // one compensated reading, plus the raw pair that produced it for the log
   typedef struct packed {
      logic signed [RESULT_W-1:0] pressure;
      logic signed [RESULT_W-1:0] temperature;
      logic [RAW_W-1:0]           raw_pressure;
      logic [RAW_W-1:0]           raw_temperature;
   } compensated_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [RAW_W-1:0]           req_raw_pressure;
   logic [RAW_W-1:0]           req_raw_temperature;
   logic                       rsp_valid;
   logic signed [RESULT_W-1:0] rsp_pressure;
   logic signed [RESULT_W-1:0] rsp_temperature;
   logic                       csr_we;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CAL_W-1:0]           csr_wdata;

   // shadow of the calibration words C1..C6, indexed by register
   logic [CAL_W-1:0] cal_word [0:CAL_LAST];

   compensated_type expected_readings [$];
   int              mismatch_count;
   int              cycle_count;
   bit              gaps_on;

   baro_sensor_compensation u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_raw_pressure    (req_raw_pressure),
      .req_raw_temperature (req_raw_temperature),
      .rsp_valid           (rsp_valid),
      .rsp_pressure        (rsp_pressure),
      .rsp_temperature     (rsp_temperature),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Compensation predictor: first-order terms, then the cold and very cold
   // corrections. Everything is 64-bit signed and every shift is arithmetic,
   // so negative terms round toward minus infinity.
   // ---------------------------------------------------------------------
   function automatic compensated_type compensate(input logic [RAW_W-1:0] d1_raw,
                                                  input logic [RAW_W-1:0] d2_raw);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, t2, tm, tp, tp2, off2, sens2, p;
      compensated_type r;
      d1 = longint'(d1_raw);
      d2 = longint'(d2_raw);
      c1 = longint'(cal_word[baro_pkg::CSR_PRESSURE_SENSITIVITY]);
      c2 = longint'(cal_word[baro_pkg::CSR_PRESSURE_OFFSET]);
      c3 = longint'(cal_word[baro_pkg::CSR_SENSITIVITY_TEMP_COEFF]);
      c4 = longint'(cal_word[baro_pkg::CSR_OFFSET_TEMP_COEFF]);
      c5 = longint'(cal_word[baro_pkg::CSR_REFERENCE_TEMPERATURE]);
      c6 = longint'(cal_word[baro_pkg::CSR_TEMPERATURE_COEFF]);

      dt   = d2 - c5 * 256;
      temp = 2000 + ((dt * c6) >>> 23);
      off  = c2 * 131072 + ((c4 * dt) >>> 6);
      sens = c1 * 65536 + ((c3 * dt) >>> 7);

      // cold: below 20.00 degC, decided on the uncorrected temperature
      if (temp < 2000) begin
         t2    = (dt * dt) >>> 31;
         tm    = temp - 2000;
         off2  = (61 * tm * tm) >>> 4;
         sens2 = 2 * tm * tm;
         // very cold: below -15.00 degC, square kept at full width
         if (temp < -1500) begin
            tp    = temp + 1500;
            tp2   = tp * tp;
            off2  = off2 + 15 * tp2;
            sens2 = sens2 + 8 * tp2;
         end
         temp = temp - t2;
         off  = off - off2;
         sens = sens - sens2;
      end

      p = ((((d1 * sens) >>> 21) - off) >>> 15);

      r.pressure        = p[RESULT_W-1:0];
      r.temperature     = temp[RESULT_W-1:0];
      r.raw_pressure    = d1_raw;
      r.raw_temperature = d2_raw;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] ERROR %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // Result checker: every strobe must match the oldest pending transaction.
   // Sampled at the rising edge, so the values seen are the pre-edge ones.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      compensated_type want;
      if (!reset && rsp_valid) begin
         if (expected_readings.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: P %0d T %0d",
                                      rsp_pressure, rsp_temperature));
         end else begin
            want = expected_readings.pop_front();
            if (rsp_pressure !== want.pressure)
               report_mismatch($sformatf("pressure %0d, want %0d (D1 %0d D2 %0d)",
                                         rsp_pressure, want.pressure,
                                         want.raw_pressure, want.raw_temperature));
            if (rsp_temperature !== want.temperature)
               report_mismatch($sformatf("temperature %0d, want %0d (D1 %0d D2 %0d)",
                                         rsp_temperature, want.temperature,
                                         want.raw_pressure, want.raw_temperature));
         end
      end
   end

   // watchdog: a run that reaches CYCLE_LIMIT is reported as a mismatch
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers. Every task is entered at a falling edge and returns at one.
   // start stays high between back-to-back transactions; it only drops in a
   // gap or when the request side parks.
   // ---------------------------------------------------------------------
   task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
      int gap;
      gap = 0;
      // random idle cycles, with noise on the data lines while start is low
      while (gaps_on && gap < MAX_GAP && $urandom_range(99) < 37) begin
         start               <= 1'b0;
         req_raw_pressure    <= RAW_W'($urandom);
         req_raw_temperature <= RAW_W'($urandom);
         gap++;
         @(negedge clock);
      end
      start               <= 1'b1;
      req_raw_pressure    <= d1;
      req_raw_temperature <= d2;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      // transaction taken at this edge; calibration is stable while in flight
      expected_readings.push_back(compensate(d1, d2));
      @(negedge clock);
   endtask

   // park the request side and wait until every pending result has come back
   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (expected_readings.size() != 0)
         @(negedge clock);
   endtask

   // single csr write; only called with the pipeline empty
   task automatic write_cal(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CAL_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      // unknown indexes are dropped by the block, so the shadow keeps its value
      if (int'(index) <= CAL_LAST)
         cal_word[index] = data;
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_index <= CSR_INDEX_W'($urandom);
      csr_wdata <= CAL_W'($urandom);
      @(negedge clock);
   endtask

   task automatic program_calibration(input logic [CAL_W-1:0] words [0:CAL_LAST]);
      baro_pkg::csr_index_type idx;
      idx = idx.first();
      repeat (idx.num()) begin
         write_cal(idx, words[idx]);
         idx = idx.next();
      end
   endtask

   function automatic logic [CAL_W-1:0] random_cal_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return CAL_MAX;
         default: return CAL_W'($urandom);
      endcase
   endfunction

   // D2 relative to the reference point C5*256, clamped to the ADC range
   function automatic logic [RAW_W-1:0] raw_temp_at(input longint dt);
      longint v;
      v = longint'(cal_word[baro_pkg::CSR_REFERENCE_TEMPERATURE]) * 256 + dt;
      if (v < 0)
         v = 0;
      if (v > longint'(RAW_MAX))
         v = longint'(RAW_MAX);
      return v[RAW_W-1:0];
   endfunction

   // random pair: full range, near the 20 degC knee, or anywhere on the cold side
   task automatic send_random_reading();
      logic [RAW_W-1:0] d1, d2;
      d1 = RAW_W'($urandom);
      case ($urandom_range(2))
         0:       d2 = RAW_W'($urandom);
         1:       d2 = raw_temp_at(longint'($urandom_range(131072)) - 65536);
         default: d2 = raw_temp_at(-longint'($urandom_range(RAW_MAX)));
      endcase
      send_reading(d1, d2);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // factory calibration: a typical room-temperature pair and the ADC corners
   task automatic test_default_calibration();
      send_reading(24'd6465444, 24'd8077636);
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading('0, RAW_MAX);
      send_reading(RAW_MAX, '0);
   endtask

   // C6 = 2^15 makes TEMP = 2000 + floor(dT/256), so the knees are exact
   task automatic test_temperature_knees();
      logic [CAL_W-1:0] saved_c6;
      saved_c6 = cal_word[baro_pkg::CSR_TEMPERATURE_COEFF];
      wait_drained();
      write_cal(baro_pkg::CSR_TEMPERATURE_COEFF, 16'h8000);
      send_reading(RAW_W'($urandom), raw_temp_at(0));        // exactly 20.00, no correction
      send_reading(RAW_W'($urandom), raw_temp_at(255));      // still 20.00
      send_reading(RAW_W'($urandom), raw_temp_at(-1));       // 19.99, cold path
      send_reading(RAW_W'($urandom), raw_temp_at(-896000));  // exactly -15.00, cold only
      send_reading(RAW_W'($urandom), raw_temp_at(-896001));  // -15.01, very cold
      wait_drained();
      write_cal(baro_pkg::CSR_TEMPERATURE_COEFF, saved_c6);
   endtask

   // all-zero and all-one calibration words against the ADC corners
   task automatic test_calibration_extremes();
      logic [CAL_W-1:0] words [0:CAL_LAST];
      logic [CAL_W-1:0] saved [0:CAL_LAST];
      saved = cal_word;
      wait_drained();
      foreach (words[i])
         words[i] = '0;
      program_calibration(words);
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      wait_drained();
      foreach (words[i])
         words[i] = CAL_MAX;
      program_calibration(words);
      send_reading(RAW_MAX, '0);   // most negative dT the fields allow
      send_reading('0, RAW_MAX);
      send_reading(RAW_MAX, RAW_MAX);
      wait_drained();
      program_calibration(saved);
   endtask

   // writes to undecoded indexes must leave the calibration untouched
   task automatic test_unmapped_index();
      wait_drained();
      write_cal(CSR_UNMAPPED_LO, CAL_W'($urandom));
      write_cal(CSR_UNMAPPED_HI, CAL_MAX);
      send_reading(24'd6465444, 24'd8077636);
      send_random_reading();
   endtask

   // random calibration sets, each followed by a run of random transactions;
   // the first set is the factory one written back explicitly
   task automatic test_random_calibrations();
      logic [CAL_W-1:0] words [0:CAL_LAST];
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         wait_drained();
         if (phase == 0) begin
            words[baro_pkg::CSR_PRESSURE_SENSITIVITY]   = baro_pkg::C1_RESET;
            words[baro_pkg::CSR_PRESSURE_OFFSET]        = baro_pkg::C2_RESET;
            words[baro_pkg::CSR_SENSITIVITY_TEMP_COEFF] = baro_pkg::C3_RESET;
            words[baro_pkg::CSR_OFFSET_TEMP_COEFF]      = baro_pkg::C4_RESET;
            words[baro_pkg::CSR_REFERENCE_TEMPERATURE]  = baro_pkg::C5_RESET;
            words[baro_pkg::CSR_TEMPERATURE_COEFF]      = baro_pkg::C6_RESET;
         end else begin
            foreach (words[i])
               words[i] = random_cal_word();
         end
         program_calibration(words);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // one pause mid-stream until the pipeline has fully emptied
            if (phase == 3 && n == PHASE_ITEMS / 2)
               wait_drained();
            send_random_reading();
         end
      end
   endtask

   // a long stretch with start held high every cycle
   task automatic test_back_to_back();
      gaps_on = 1'b0;
      repeat (BURST_ITEMS)
         send_random_reading();
      gaps_on = 1'b1;
   endtask

   initial begin
      reset               = 1'b1;
      start               = 1'b0;
      req_raw_pressure    = '0;
      req_raw_temperature = '0;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      mismatch_count      = 0;
      gaps_on             = 1'b1;

      cal_word[baro_pkg::CSR_PRESSURE_SENSITIVITY]   = baro_pkg::C1_RESET;
      cal_word[baro_pkg::CSR_PRESSURE_OFFSET]        = baro_pkg::C2_RESET;
      cal_word[baro_pkg::CSR_SENSITIVITY_TEMP_COEFF] = baro_pkg::C3_RESET;
      cal_word[baro_pkg::CSR_OFFSET_TEMP_COEFF]      = baro_pkg::C4_RESET;
      cal_word[baro_pkg::CSR_REFERENCE_TEMPERATURE]  = baro_pkg::C5_RESET;
      cal_word[baro_pkg::CSR_TEMPERATURE_COEFF]      = baro_pkg::C6_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_calibration();
      test_temperature_knees();
      test_calibration_extremes();
      test_unmapped_index();
      test_random_calibrations();
      test_back_to_back();

      // drain, then give stray strobes time to show up
      wait_drained();
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* baro_sensor_compensation.f */
rtl/core/baro_pkg.sv
rtl/core/baro_sensor_compensation.sv
dv/baro_sensor_compensation_tb.sv
